// File: hdl/pia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int REQ_W   = 2;
    localparam int COUNT_W = 8;

    // default number of element cells
    localparam int CAPACITY_DEF = 128;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2
    } t_req;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: hdl/positional_insert_delete_array.sv
// positional insert/delete array
//
// keeps an ordered list of up to CAPACITY signed 32-bit words in a row of
// cells, one word per cell, plus an element count. each cell loads from its
// left or right neighbor, so an insert or a delete shifts the whole tail
// at once.
//
// input channel: i_in_valid / o_in_ready carry a request word (type,
// position, value). output channel: o_out_valid / i_out_ready carry the
// result word (ok, read value, count after the request).
// the result word is registered and appears in the cycle after the request is taken.
// throughput: one request per cycle while the receiver takes each result;
// the single shift of the cell row and the position select set that figure.
// when the receiver stalls, the result stays in the output register and the
// input side takes one more request only in the cycle the result leaves.
// reset clears the count and the output valid; cell contents are left as
// they are and are never read before being written.

`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array #(
    parameter int CAPACITY = pia_pkg::CAPACITY_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [pia_pkg::REQ_W-1:0]        i_req_type,
    input  wire  [pia_pkg::POS_W-1:0]        i_position,
    input  wire  signed [pia_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_ok,
    output logic signed [pia_pkg::DATA_W-1:0] o_read_value,
    output logic [pia_pkg::COUNT_W-1:0]      o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = CNT_W + pia_pkg::POS_W + 1;

    logic [pia_pkg::DATA_W-1:0] cell_data [CAPACITY];
    pia_pkg::t_cell_cmd         cmd;

    logic [CNT_W-1:0]           r_elem_count;
    logic [CNT_W-1:0]           n_elem_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_ok;
    logic                       n_ok;
    logic [pia_pkg::DATA_W-1:0] r_rd;
    logic [pia_pkg::DATA_W-1:0] n_rd;
    logic [pia_pkg::COUNT_W-1:0] r_cnt_out;
    logic [pia_pkg::COUNT_W-1:0] n_cnt_out;

    logic                       accept;
    logic [CW-1:0]              pos_ext;
    logic [CW-1:0]              cnt_ext;
    logic [CW-1:0]              cnt_after;
    logic                       ins_ok;
    logic                       del_ok;
    logic [pia_pkg::DATA_W-1:0] sel_word;

    // take a word when the result register is free or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_ext = CW'(i_position);
    assign cnt_ext = CW'(r_elem_count);
    assign ins_ok  = (pos_ext <= cnt_ext) && (cnt_ext < CW'(CAPACITY));
    assign del_ok  = pos_ext < cnt_ext;

    // select the addressed cell for a read
    always_comb begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CW'(k) == pos_ext) begin
                sel_word = cell_data[k];
            end
        end
    end

    // decode the request
    always_comb begin
        cmd.ins      = 1'b0;
        cmd.del      = 1'b0;
        cmd.pos      = i_position;
        n_elem_count = r_elem_count;
        n_ok         = 1'b0;
        n_rd         = '0;
        case (pia_pkg::t_req'(i_req_type))
            pia_pkg::REQ_INSERT: begin
                if (ins_ok) begin
                    cmd.ins      = accept;
                    n_elem_count = r_elem_count + CNT_W'(1);
                    n_ok         = 1'b1;
                end
            end
            pia_pkg::REQ_DELETE: begin
                if (del_ok) begin
                    cmd.del      = accept;
                    n_elem_count = r_elem_count - CNT_W'(1);
                    n_ok         = 1'b1;
                end
            end
            pia_pkg::REQ_READ: begin
                if (del_ok) begin
                    n_rd = sel_word;
                    n_ok = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // low count bits for the result word
    assign cnt_after = CW'(n_elem_count);
    assign n_cnt_out = cnt_after[pia_pkg::COUNT_W-1:0];

    // output valid follows accept and drain
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_elem_count <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_elem_count <= n_elem_count;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok      <= n_ok;
            r_rd      <= n_rd;
            r_cnt_out <= n_cnt_out;
        end
    end

    // row of element cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [pia_pkg::DATA_W-1:0] left_w;
        logic [pia_pkg::DATA_W-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = cell_data[g];
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        pia_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_value (i_value),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (cell_data[g])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_count      = r_cnt_out;

endmodule

`default_nettype wire

// File: hdl/pia_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pia_cell #(
    parameter int CAPACITY = pia_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  wire                             i_clk,
    input  wire  pia_pkg::t_cell_cmd        i_cmd,
    input  wire  [pia_pkg::DATA_W-1:0]      i_value,
    input  wire  [pia_pkg::DATA_W-1:0]      i_left,
    input  wire  [pia_pkg::DATA_W-1:0]      i_right,
    output logic [pia_pkg::DATA_W-1:0]      o_data
);

    // compare width covers both the cell index and the request position
    localparam int IW = $clog2(CAPACITY) + pia_pkg::POS_W + 1;

    logic [IW-1:0]              my_idx;
    logic [IW-1:0]              pos_ext;
    logic [pia_pkg::DATA_W-1:0] r_data;
    logic [pia_pkg::DATA_W-1:0] n_data;

    assign my_idx  = IW'(INDEX);
    assign pos_ext = IW'(i_cmd.pos);

    // take the neighbor's word, the new word, or hold
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (my_idx > pos_ext) begin
                n_data = i_left;
            end else if (my_idx == pos_ext) begin
                n_data = i_value;
            end
        end else if (i_cmd.del) begin
            if (my_idx >= pos_ext) begin
                n_data = i_right;
            end
        end
    end

    // element storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
